FILE: rtl/core/sfc_pkg.sv
// shared types, codes and frame helpers for the serial flash command sequencer
package sfc_pkg;

	localparam int ADDR_W = 24;
	localparam int AMT_W  = 13;
	localparam int IDX_W  = 13;
	localparam int LEN_W  = 14;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic [7:0] OPC_WREN  = 8'h06;
	localparam logic [7:0] OPC_RDSR  = 8'h05;
	localparam logic [7:0] OPC_WRSR  = 8'h01;
	localparam logic [7:0] OPC_CE    = 8'hC7;
	localparam logic [7:0] OPC_SE    = 8'h20;
	localparam logic [7:0] OPC_BE    = 8'hD8;
	localparam logic [7:0] OPC_PP    = 8'h02;
	localparam logic [7:0] OPC_READ  = 8'h03;
	localparam logic [7:0] OPC_RDID  = 8'h9F;
	localparam logic [7:0] OPC_RSTEN = 8'h66;
	localparam logic [7:0] OPC_RST   = 8'h99;
	localparam logic [7:0] DUMMY     = 8'hFF;

	localparam logic [AMT_W-1:0] ERASE_CHIP   = 13'd0;
	localparam logic [AMT_W-1:0] ERASE_SECTOR = 13'd1;
	localparam logic [AMT_W-1:0] ERASE_BLOCK  = 13'd2;

	typedef enum logic [1:0] {
		REQ_OP   = 2'd0,
		REQ_PROG = 2'd1,
		REQ_RX   = 2'd2
	} req_kind_t;

	typedef enum logic [2:0] {
		OP_RDSR  = 3'd0,
		OP_WRSR  = 3'd1,
		OP_ERASE = 3'd2,
		OP_PROG  = 3'd3,
		OP_READ  = 3'd4,
		OP_RDID  = 3'd5,
		OP_RSTEN = 3'd6,
		OP_RST   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		KIND_TX   = 2'd0,
		KIND_RET  = 2'd1,
		KIND_DONE = 2'd2,
		KIND_REJ  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_WREN      = 4'd1,
		PH_FRAME     = 4'd2,
		PH_PROG_WAIT = 4'd3,
		PH_POLL_CMD  = 4'd4,
		PH_POLL_DATA = 4'd5
	} phase_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [2:0]        op;
		logic [ADDR_W-1:0] address;
		logic [AMT_W-1:0]  amount;
		logic [7:0]        data_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       keep_select;
		logic       last;
	} res_t;

	// up to two result beats per processed item; b is only valid with a
	typedef struct packed {
		logic a_v;
		logic b_v;
		res_t a;
		res_t b;
	} push_t;

	function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] b,
			input logic keep);
		res_t r;
		r.kind        = kind;
		r.out_byte    = b;
		r.keep_select = keep;
		r.last        = 1'b0;
		return r;
	endfunction

	function automatic logic is_write_op(input logic [2:0] op);
		return (op == OP_WRSR) || (op == OP_ERASE) || (op == OP_PROG);
	endfunction

	function automatic logic [LEN_W-1:0] frame_len(input logic [2:0] op,
			input logic [AMT_W-1:0] amt, input logic [LEN_W-1:0] page_len);
		logic [LEN_W-1:0] len;
		case (op)
			OP_RDSR:  len = 14'd2;
			OP_WRSR:  len = 14'd2;
			OP_ERASE: len = (amt == ERASE_CHIP) ? 14'd1 : 14'd4;
			OP_PROG:  len = 14'd4 + page_len;
			OP_READ:  len = 14'd4 + {1'b0, amt};
			OP_RDID:  len = 14'd4;
			default:  len = 14'd1;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] frame_byte(input logic [2:0] op,
			input logic [IDX_W-1:0] k, input logic [AMT_W-1:0] amt,
			input logic [ADDR_W-1:0] addr, input logic [7:0] status);
		logic [7:0] ab;
		logic [7:0] fb;
		case (k)
			13'd1:   ab = addr[23:16];
			13'd2:   ab = addr[15:8];
			13'd3:   ab = addr[7:0];
			default: ab = 8'h00;
		endcase
		case (op)
			OP_RDSR:  fb = (k == 13'd0) ? OPC_RDSR : DUMMY;
			OP_WRSR:  fb = (k == 13'd0) ? OPC_WRSR : status;
			OP_ERASE: begin
				if (k != 13'd0)
					fb = ab;
				else if (amt == ERASE_CHIP)
					fb = OPC_CE;
				else if (amt == ERASE_SECTOR)
					fb = OPC_SE;
				else
					fb = OPC_BE;
			end
			OP_PROG:  fb = (k == 13'd0) ? OPC_PP : ab;
			OP_READ:  fb = (k == 13'd0) ? OPC_READ : ((k <= 13'd3) ? ab : DUMMY);
			OP_RDID:  fb = (k == 13'd0) ? OPC_RDID : DUMMY;
			OP_RSTEN: fb = OPC_RSTEN;
			default:  fb = OPC_RST;
		endcase
		return fb;
	endfunction

	function automatic logic returns_data(input logic [2:0] op, input logic [IDX_W-1:0] k);
		logic r;
		case (op)
			OP_RDSR: r = (k >= 13'd1);
			OP_RDID: r = (k >= 13'd1);
			OP_READ: r = (k >= 13'd4);
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/sfc_req_if.sv
// request channel: operation requests, program bytes and received serial bytes
interface sfc_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 req_type;
	logic [2:0]                 op;
	logic [sfc_pkg::ADDR_W-1:0] address;
	logic [sfc_pkg::AMT_W-1:0]  amount;
	logic [7:0]                 data_byte;

	modport source(output valid, req_type, op, address, amount, data_byte, input ready);
	modport sink(input valid, req_type, op, address, amount, data_byte, output ready);
endinterface

FILE: rtl/core/sfc_res_if.sv
// result channel: transmit bytes, returned bytes and completion codes
interface sfc_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       keep_select;
	logic       last;

	modport source(output valid, kind, out_byte, keep_select, last, input ready);
	modport sink(input valid, kind, out_byte, keep_select, last, output ready);
endinterface

FILE: rtl/core/sfc_engine.sv
// command sequencing state and per-beat result generation
module sfc_engine #(
	parameter int SECTOR_SIZE = 4096,
	parameter int PAGE_BYTES  = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  sfc_pkg::req_t   item,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	output sfc_pkg::push_t  push
);

	localparam logic [sfc_pkg::LEN_W-1:0] PageLen = PAGE_BYTES[sfc_pkg::LEN_W-1:0];
	localparam logic [16:0] SectorLim = SECTOR_SIZE[16:0];

	sfc_pkg::phase_t              phase_q, phase_d;
	logic [2:0]                   op_q, op_d;
	logic [sfc_pkg::IDX_W-1:0]    idx_q, idx_d;
	logic [sfc_pkg::ADDR_W-1:0]   addr_q, addr_d;
	logic [sfc_pkg::AMT_W-1:0]    amt_q, amt_d;
	logic [7:0]                   status_q, status_d;
	logic [7:0]                   mask_q;

	logic                         rej;
	logic                         new_write;
	logic                         cur_write;
	logic [sfc_pkg::LEN_W-1:0]    len_new;
	logic [sfc_pkg::LEN_W-1:0]    len_cur;
	logic [sfc_pkg::LEN_W-1:0]    idx_inc;
	logic [sfc_pkg::IDX_W-1:0]    idx_nxt;
	logic [sfc_pkg::LEN_W-1:0]    nxt_inc;
	logic                         more;
	logic                         ret;
	logic                         to_wait;
	logic                         busy;

	sfc_pkg::res_t                ra, rb, ret_res, sec;
	logic                         ra_v, rb_v, sec_v;

	always_comb begin
		rej = (phase_q != sfc_pkg::PH_IDLE)
			|| (item.op == sfc_pkg::OP_ERASE && item.amount > sfc_pkg::ERASE_BLOCK)
			|| (item.op == sfc_pkg::OP_READ
				&& (item.amount == '0 || {4'b0, item.amount} > SectorLim));
		new_write = sfc_pkg::is_write_op(item.op);
		cur_write = sfc_pkg::is_write_op(op_q);
		len_new   = sfc_pkg::frame_len(item.op, item.amount, PageLen);
		len_cur   = sfc_pkg::frame_len(op_q, amt_q, PageLen);
		// index wraps at its own width, the length compare does not
		idx_inc   = {1'b0, idx_q} + 14'd1;
		idx_nxt   = idx_inc[sfc_pkg::IDX_W-1:0];
		nxt_inc   = {1'b0, idx_nxt} + 14'd1;
		more      = idx_inc < len_cur;
		ret       = sfc_pkg::returns_data(op_q, idx_q);
		to_wait   = (op_q == sfc_pkg::OP_PROG) && (idx_nxt >= 13'd4);
		busy      = (item.data_byte & mask_q) != 8'h00;
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		op_d     = op_q;
		idx_d    = idx_q;
		addr_d   = addr_q;
		amt_d    = amt_q;
		status_d = status_q;
		if (go) begin
			case (item.req_type)
				sfc_pkg::REQ_OP: begin
					if (!rej) begin
						op_d   = item.op;
						addr_d = item.address;
						amt_d  = item.amount;
						idx_d  = '0;
						if (item.op == sfc_pkg::OP_WRSR)
							status_d = item.data_byte;
						phase_d = new_write ? sfc_pkg::PH_WREN : sfc_pkg::PH_FRAME;
					end
				end
				sfc_pkg::REQ_PROG: begin
					if (phase_q == sfc_pkg::PH_PROG_WAIT)
						phase_d = sfc_pkg::PH_FRAME;
				end
				sfc_pkg::REQ_RX: begin
					case (phase_q)
						sfc_pkg::PH_WREN: begin
							phase_d = sfc_pkg::PH_FRAME;
							idx_d   = '0;
						end
						sfc_pkg::PH_FRAME: begin
							if (ret && op_q == sfc_pkg::OP_RDSR)
								status_d = item.data_byte;
							if (more) begin
								idx_d = idx_nxt;
								if (to_wait)
									phase_d = sfc_pkg::PH_PROG_WAIT;
							end else begin
								phase_d = cur_write ? sfc_pkg::PH_POLL_CMD : sfc_pkg::PH_IDLE;
							end
						end
						sfc_pkg::PH_POLL_CMD: phase_d = sfc_pkg::PH_POLL_DATA;
						sfc_pkg::PH_POLL_DATA: begin
							status_d = item.data_byte;
							phase_d  = busy ? sfc_pkg::PH_POLL_CMD : sfc_pkg::PH_IDLE;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// result beats
	always_comb begin
		ra      = sfc_pkg::mk_res(sfc_pkg::KIND_TX, 8'h00, 1'b0);
		rb      = ra;
		ra_v    = 1'b0;
		rb_v    = 1'b0;
		ret_res = sfc_pkg::mk_res(sfc_pkg::KIND_RET, item.data_byte, 1'b0);
		sec_v   = 1'b1;
		if (more) begin
			if (to_wait)
				sec_v = 1'b0;
			sec = sfc_pkg::mk_res(sfc_pkg::KIND_TX,
				sfc_pkg::frame_byte(op_q, idx_nxt, amt_q, addr_q, status_q),
				nxt_inc < len_cur);
		end else if (cur_write) begin
			sec = sfc_pkg::mk_res(sfc_pkg::KIND_TX, sfc_pkg::OPC_RDSR, 1'b1);
		end else begin
			sec = sfc_pkg::mk_res(sfc_pkg::KIND_DONE, 8'h00, 1'b0);
		end

		if (go) begin
			case (item.req_type)
				sfc_pkg::REQ_OP: begin
					ra_v = 1'b1;
					if (rej)
						ra = sfc_pkg::mk_res(sfc_pkg::KIND_REJ, 8'h00, 1'b0);
					else if (new_write)
						ra = sfc_pkg::mk_res(sfc_pkg::KIND_TX, sfc_pkg::OPC_WREN, 1'b0);
					else
						ra = sfc_pkg::mk_res(sfc_pkg::KIND_TX,
							sfc_pkg::frame_byte(item.op, '0, item.amount, item.address,
								status_q),
							len_new > 14'd1);
				end
				sfc_pkg::REQ_PROG: begin
					if (phase_q == sfc_pkg::PH_PROG_WAIT) begin
						ra_v = 1'b1;
						ra   = sfc_pkg::mk_res(sfc_pkg::KIND_TX, item.data_byte, more);
					end
				end
				sfc_pkg::REQ_RX: begin
					case (phase_q)
						sfc_pkg::PH_WREN: begin
							ra_v = 1'b1;
							ra   = sfc_pkg::mk_res(sfc_pkg::KIND_TX,
								sfc_pkg::frame_byte(op_q, '0, amt_q, addr_q, status_q),
								len_cur > 14'd1);
						end
						sfc_pkg::PH_FRAME: begin
							if (ret) begin
								ra_v = 1'b1;
								ra   = ret_res;
								rb_v = sec_v;
								rb   = sec;
							end else begin
								ra_v = sec_v;
								ra   = sec;
							end
						end
						sfc_pkg::PH_POLL_CMD: begin
							ra_v = 1'b1;
							ra   = sfc_pkg::mk_res(sfc_pkg::KIND_TX, sfc_pkg::DUMMY, 1'b0);
						end
						sfc_pkg::PH_POLL_DATA: begin
							ra_v = 1'b1;
							if (busy)
								ra = sfc_pkg::mk_res(sfc_pkg::KIND_TX, sfc_pkg::OPC_RDSR, 1'b1);
							else
								ra = sfc_pkg::mk_res(sfc_pkg::KIND_DONE, item.data_byte, 1'b0);
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end

		if (rb_v)
			rb.last = 1'b1;
		else if (ra_v)
			ra.last = 1'b1;

		push.a_v = ra_v;
		push.b_v = rb_v;
		push.a   = ra;
		push.b   = rb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= sfc_pkg::PH_IDLE;
			op_q     <= '0;
			idx_q    <= '0;
			addr_q   <= '0;
			amt_q    <= '0;
			status_q <= '0;
			mask_q   <= 8'h01;
		end else begin
			phase_q  <= phase_d;
			op_q     <= op_d;
			idx_q    <= idx_d;
			addr_q   <= addr_d;
			amt_q    <= amt_d;
			status_q <= status_d;
			if (cfg_we)
				mask_q <= cfg_wdata;
		end
	end

endmodule

FILE: rtl/core/sfc_out_fifo.sv
// four-entry result queue taking up to two beats and giving one per cycle while the result side is ready
module sfc_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  sfc_pkg::push_t push,
	output logic           room,
	sfc_res_if.source      res
);

	sfc_pkg::res_t                  mem_q [sfc_pkg::FIFO_DEPTH];
	logic [sfc_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [sfc_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic                           pop;
	sfc_pkg::res_t                  head;

	assign room = cnt_q <= 3'd2;
	assign pop  = res.valid && res.ready;
	assign head = mem_q[rd_q];

	assign res.valid       = cnt_q != '0;
	assign res.kind        = head.kind;
	assign res.out_byte    = head.out_byte;
	assign res.keep_select = head.keep_select;
	assign res.last        = head.last;

	always_ff @(posedge clk) begin
		if (push.a_v)
			mem_q[wr_q] <= push.a;
		if (push.b_v)
			mem_q[wr_q + 2'd1] <= push.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + {1'b0, push.a_v} + {1'b0, push.b_v};
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {2'b0, push.a_v} + {2'b0, push.b_v} - {2'b0, pop};
		end
	end

endmodule

FILE: rtl/core/spi_nor_flash_command_sequencer_top.sv
// top level of the serial nor flash command sequencer
// Takes operation requests, program data bytes and received serial bytes on the req
// channel and hands out transmit bytes (with a keep-select mark), returned data bytes
// and done or reject codes on the res channel. Every transmit beat must be answered by
// one received-byte request before the sequence moves on; write operations send write
// enable first and poll status until (status & busy_mask) is zero. One request is
// taken per cycle while the result queue has room for two beats; each request
// produces zero, one or two result beats, so sustained rate is one request per cycle
// when each request yields at most one beat and the result side takes one beat per
// cycle. A request passes through one input register, then the sequencing logic writes
// its result beats into the four-entry result queue.
module spi_nor_flash_command_sequencer_top #(
	parameter int SECTOR_SIZE = 4096,
	parameter int PAGE_BYTES  = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	sfc_req_if.sink    req,
	sfc_res_if.source  res,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic           valid_s1;
	sfc_pkg::req_t  item_s1;
	logic           room;
	logic           go;
	logic           accept;
	sfc_pkg::push_t push;

	assign go        = valid_s1 && room;
	assign req.ready = !valid_s1 || room;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (go)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.req_type  <= req.req_type;
			item_s1.op        <= req.op;
			item_s1.address   <= req.address;
			item_s1.amount    <= req.amount;
			item_s1.data_byte <= req.data_byte;
		end
	end

	sfc_engine #(
		.SECTOR_SIZE(SECTOR_SIZE),
		.PAGE_BYTES (PAGE_BYTES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.item     (item_s1),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.push     (push)
	);

	sfc_out_fifo u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.res   (res)
	);

endmodule

FILE: verif/tb_spi_nor_flash_command_sequencer_top.sv
// testbench for the serial nor flash command sequencer: directed table, then random traffic
module tb_spi_nor_flash_command_sequencer_top;
	import sfc_pkg::*;

	localparam int SECTOR_SIZE   = 4096;
	localparam int PAGE_BYTES    = 256;
	localparam int MAX_GAP       = 10;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 180;
	localparam int PREDICT       = -1;

	localparam logic [1:0] REQ_NONE = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	sfc_req_if req_ch();
	sfc_res_if res_ch();

	spi_nor_flash_command_sequencer_top #(
		.SECTOR_SIZE(SECTOR_SIZE),
		.PAGE_BYTES (PAGE_BYTES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// sequencer state as the testbench sees it
	phase_t      seq_phase;
	logic [2:0]  seq_op;
	logic [12:0] seq_idx;
	logic [23:0] seq_addr;
	logic [12:0] seq_amt;
	logic [7:0]  seq_stat;
	logic [7:0]  busy_mask_q;

	res_t step_beats[$];
	res_t beats_due[$];
	int   err_cnt;
	bit   no_idle;
	bit   want_max_read;

	typedef struct {
		req_t item;
		int   n_typed;
		res_t typed_beat;
	} dir_row_t;

	function automatic int pick_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic int unsigned frame_bytes();
		case (seq_op)
			OP_RDSR, OP_WRSR: return 2;
			OP_ERASE: return (seq_amt == ERASE_CHIP) ? 1 : 4;
			OP_PROG:  return 4 + PAGE_BYTES;
			OP_READ:  return 4 + int'(seq_amt);
			OP_RDID:  return 4;
			default:  return 1;
		endcase
	endfunction

	function automatic logic [7:0] frame_tx_byte(input int unsigned k);
		logic [7:0] ab;
		ab = 8'h00;
		if (k >= 1 && k <= 3)
			ab = 8'(seq_addr >> (8 * (3 - k)));
		case (seq_op)
			OP_RDSR:  return (k == 0) ? OPC_RDSR : DUMMY;
			OP_WRSR:  return (k == 0) ? OPC_WRSR : seq_stat;
			OP_ERASE: begin
				if (k != 0)
					return ab;
				if (seq_amt == ERASE_CHIP)
					return OPC_CE;
				return (seq_amt == ERASE_SECTOR) ? OPC_SE : OPC_BE;
			end
			OP_PROG:  return (k == 0) ? OPC_PP : ab;
			OP_READ:  return (k == 0) ? OPC_READ : ((k <= 3) ? ab : DUMMY);
			OP_RDID:  return (k == 0) ? OPC_RDID : DUMMY;
			OP_RSTEN: return OPC_RSTEN;
			default:  return OPC_RST;
		endcase
	endfunction

	function automatic bit writes_flash();
		return seq_op == OP_WRSR || seq_op == OP_ERASE || seq_op == OP_PROG;
	endfunction

	function automatic void put_beat(input logic [1:0] k, input logic [7:0] b, input logic keep);
		res_t r;
		r.kind        = k;
		r.out_byte    = b;
		r.keep_select = keep;
		r.last        = 1'b0;
		step_beats.push_back(r);
	endfunction

	function automatic void start_request(input req_t it);
		if (seq_phase != PH_IDLE || (it.op == OP_ERASE && it.amount > ERASE_BLOCK) ||
				(it.op == OP_READ && (it.amount == 0 || it.amount > SECTOR_SIZE))) begin
			put_beat(KIND_REJ, 8'h00, 1'b0);
			return;
		end
		seq_op   = it.op;
		seq_addr = it.address;
		seq_amt  = it.amount;
		if (it.op == OP_WRSR)
			seq_stat = it.data_byte;
		seq_idx = '0;
		if (writes_flash()) begin
			seq_phase = PH_WREN;
			put_beat(KIND_TX, OPC_WREN, 1'b0);
		end else begin
			seq_phase = PH_FRAME;
			put_beat(KIND_TX, frame_tx_byte(0), frame_bytes() > 1);
		end
	endfunction

	function automatic void answer_frame(input logic [7:0] rx);
		int unsigned len;
		int unsigned k;
		bit data_phase;
		len = frame_bytes();
		k   = seq_idx;
		case (seq_op)
			OP_RDSR, OP_RDID: data_phase = (k >= 1);
			OP_READ: data_phase = (k >= 4);
			default: data_phase = 1'b0;
		endcase
		if (data_phase) begin
			put_beat(KIND_RET, rx, 1'b0);
			if (seq_op == OP_RDSR)
				seq_stat = rx;
		end
		if (k + 1 < len) begin
			seq_idx = 13'(k + 1);
			// program data bytes come from the request side, one per answer
			if (seq_op == OP_PROG && seq_idx >= 4)
				seq_phase = PH_PROG_WAIT;
			else
				put_beat(KIND_TX, frame_tx_byte(seq_idx), int'(seq_idx) + 1 < len);
		end else if (writes_flash()) begin
			seq_phase = PH_POLL_CMD;
			put_beat(KIND_TX, OPC_RDSR, 1'b1);
		end else begin
			seq_phase = PH_IDLE;
			put_beat(KIND_DONE, 8'h00, 1'b0);
		end
	endfunction

	function automatic void advance_sequencer(input req_t it);
		step_beats.delete();
		case (it.req_type)
			REQ_OP: start_request(it);
			REQ_PROG: begin
				if (seq_phase == PH_PROG_WAIT) begin
					seq_phase = PH_FRAME;
					put_beat(KIND_TX, it.data_byte, int'(seq_idx) + 1 < frame_bytes());
				end
			end
			REQ_RX: begin
				case (seq_phase)
					PH_WREN: begin
						seq_phase = PH_FRAME;
						seq_idx   = '0;
						put_beat(KIND_TX, frame_tx_byte(0), frame_bytes() > 1);
					end
					PH_FRAME: answer_frame(it.data_byte);
					PH_POLL_CMD: begin
						seq_phase = PH_POLL_DATA;
						put_beat(KIND_TX, DUMMY, 1'b0);
					end
					PH_POLL_DATA: begin
						seq_stat = it.data_byte;
						if ((it.data_byte & busy_mask_q) != 0) begin
							seq_phase = PH_POLL_CMD;
							put_beat(KIND_TX, OPC_RDSR, 1'b1);
						end else begin
							seq_phase = PH_IDLE;
							put_beat(KIND_DONE, it.data_byte, 1'b0);
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (step_beats.size() > 0)
			step_beats[step_beats.size() - 1].last = 1'b1;
	endfunction

	function automatic req_t rq(input logic [1:0] rt, input logic [2:0] op,
			input logic [23:0] a, input logic [12:0] amt, input logic [7:0] d);
		req_t it;
		it.req_type  = rt;
		it.op        = op;
		it.address   = a;
		it.amount    = amt;
		it.data_byte = d;
		return it;
	endfunction

	function automatic res_t lone_beat(input logic [1:0] k, input logic [7:0] b, input logic keep);
		res_t r;
		r.kind        = k;
		r.out_byte    = b;
		r.keep_select = keep;
		r.last        = 1'b1;
		return r;
	endfunction

	// mostly what a well-behaved host and flash would send next, with some noise
	function automatic req_t next_item();
		req_t it;
		int unsigned roll;
		logic [2:0] pick;
		it = rq(REQ_RX, 3'($urandom), 24'($urandom), 13'($urandom), 8'($urandom));
		roll = $urandom_range(0, 99);
		if (seq_phase == PH_IDLE) begin
			if (roll < 88) begin
				it.req_type = REQ_OP;
				if ($urandom_range(0, 99) < 2) begin
					it.op = OP_PROG;
				end else begin
					pick  = 3'($urandom_range(0, 6));
					it.op = (pick >= 3'd3) ? pick + 3'd1 : pick;
				end
				if (want_max_read) begin
					it.op         = OP_READ;
					it.amount     = 13'(SECTOR_SIZE);
					want_max_read = 1'b0;
				end else if (it.op == OP_ERASE) begin
					it.amount = ($urandom_range(0, 9) != 0) ? 13'($urandom_range(0, 2)) :
						13'($urandom_range(3, 8191));
				end else if (it.op == OP_READ) begin
					roll = $urandom_range(0, 99);
					if (roll < 3)
						it.amount = '0;
					else if (roll < 7)
						it.amount = 13'($urandom_range(SECTOR_SIZE + 1, 8191));
					else if (roll < 12)
						it.amount = 13'($urandom_range(9, 64));
					else
						it.amount = 13'($urandom_range(1, 8));
				end
			end else begin
				it.req_type = 2'($urandom_range(1, 3));
			end
		end else if (seq_phase == PH_PROG_WAIT) begin
			it.req_type = (roll < 92) ? REQ_PROG : 2'($urandom_range(0, 3));
		end else if (roll < 93) begin
			if (seq_phase == PH_POLL_DATA)
				it.data_byte = $urandom_range(0, 1) ? (it.data_byte | busy_mask_q) :
					(it.data_byte & ~busy_mask_q);
		end else begin
			it.req_type = 2'($urandom_range(0, 3));
		end
		return it;
	endfunction

	task automatic send_item(input req_t it, input int n_typed, input res_t typed_beat);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= it.req_type;
		req_ch.op        <= it.op;
		req_ch.address   <= it.address;
		req_ch.amount    <= it.amount;
		req_ch.data_byte <= it.data_byte;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		advance_sequencer(it);
		if (n_typed == PREDICT)
			foreach (step_beats[i])
				beats_due.push_back(step_beats[i]);
		else if (n_typed == 1)
			beats_due.push_back(typed_beat);
	endtask

	// stop sending and let every outstanding beat come back
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_busy_mask(input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we      <= 1'b0;
		busy_mask_q  = v;
	endtask

	initial begin : stim
		dir_row_t    dir_tab[$];
		logic [7:0]  mask_plan [5];
		int unsigned counted;
		res_t        no_beat;

		no_beat       = '0;
		err_cnt       = 0;
		no_idle       = 1'b0;
		want_max_read = 1'b0;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= 8'h00;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_OP;
		req_ch.op          <= OP_RDSR;
		req_ch.address     <= '0;
		req_ch.amount      <= '0;
		req_ch.data_byte   <= 8'h00;
		busy_mask_q = 8'h01;
		seq_phase   = PH_IDLE;
		seq_op      = '0;
		seq_idx     = '0;
		seq_addr    = '0;
		seq_amt     = '0;
		seq_stat    = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_tab.push_back('{rq(REQ_RX, OP_RDSR, 24'h0, 13'd0, 8'h00), 0, no_beat});
		dir_tab.push_back('{rq(REQ_NONE, OP_RST, 24'hFFFFFF, 13'h1FFF, 8'hFF), 0, no_beat});
		dir_tab.push_back('{rq(REQ_OP, OP_ERASE, 24'hFFFFFF, 13'd3, 8'h00), 1,
			lone_beat(KIND_REJ, 8'h00, 1'b0)});
		dir_tab.push_back('{rq(REQ_OP, OP_READ, 24'h0, 13'd0, 8'h00), 1,
			lone_beat(KIND_REJ, 8'h00, 1'b0)});
		dir_tab.push_back('{rq(REQ_OP, OP_READ, 24'h0, 13'(SECTOR_SIZE + 1), 8'h00), 1,
			lone_beat(KIND_REJ, 8'h00, 1'b0)});
		dir_tab.push_back('{rq(REQ_OP, OP_RSTEN, 24'h0, 13'd0, 8'h00), 1,
			lone_beat(KIND_TX, OPC_RSTEN, 1'b0)});
		dir_tab.push_back('{rq(REQ_RX, OP_RDSR, 24'h0, 13'd0, 8'h00), 1,
			lone_beat(KIND_DONE, 8'h00, 1'b0)});
		dir_tab.push_back('{rq(REQ_OP, OP_RST, 24'h0, 13'd0, 8'hFF), 1,
			lone_beat(KIND_TX, OPC_RST, 1'b0)});
		dir_tab.push_back('{rq(REQ_RX, OP_RDSR, 24'h0, 13'd0, 8'hFF), 1,
			lone_beat(KIND_DONE, 8'h00, 1'b0)});
		dir_tab.push_back('{rq(REQ_OP, OP_READ, 24'hFFFFFF, 13'd1, 8'h00), 1,
			lone_beat(KIND_TX, OPC_READ, 1'b1)});
		// a request while busy is turned away, a stray program byte is dropped
		dir_tab.push_back('{rq(REQ_OP, OP_RDSR, 24'h0, 13'd0, 8'h00), 1,
			lone_beat(KIND_REJ, 8'h00, 1'b0)});
		dir_tab.push_back('{rq(REQ_PROG, OP_RDSR, 24'h0, 13'd0, 8'h5A), 0, no_beat});
		repeat (4)
			dir_tab.push_back('{rq(REQ_RX, OP_RDSR, 24'h0, 13'd0, 8'h00), PREDICT, no_beat});
		dir_tab.push_back('{rq(REQ_RX, OP_RDSR, 24'h0, 13'd0, 8'hA5), PREDICT, no_beat});
		dir_tab.push_back('{rq(REQ_OP, OP_WRSR, 24'h0, 13'd0, 8'hFF), 1,
			lone_beat(KIND_TX, OPC_WREN, 1'b0)});
		repeat (4)
			dir_tab.push_back('{rq(REQ_RX, OP_RDSR, 24'h0, 13'd0, 8'h00), PREDICT, no_beat});
		// status still busy once, then clear
		dir_tab.push_back('{rq(REQ_RX, OP_RDSR, 24'h0, 13'd0, 8'h01), PREDICT, no_beat});
		dir_tab.push_back('{rq(REQ_RX, OP_RDSR, 24'h0, 13'd0, 8'h00), PREDICT, no_beat});
		dir_tab.push_back('{rq(REQ_RX, OP_RDSR, 24'h0, 13'd0, 8'hFE), PREDICT, no_beat});

		foreach (dir_tab[i])
			send_item(dir_tab[i].item, dir_tab[i].n_typed, dir_tab[i].typed_beat);
		settle();

		mask_plan = '{8'h00, 8'hFF, 8'($urandom), 8'h80, 8'($urandom)};
		for (int ph = 0; ph < 5; ph++) begin
			write_busy_mask(mask_plan[ph]);
			no_idle       = (ph == 1);
			want_max_read = (ph == 2);
			counted       = 0;
			while (counted < PHASE_ITEMS) begin
				send_item(next_item(), PREDICT, no_beat);
				if (step_beats.size() > 0)
					counted++;
				if ($urandom_range(0, 199) == 0)
					settle();
			end
			settle();
		end

		if (err_cnt == 0 && beats_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// beats are shown as kind/byte/keep/last
	initial begin : beat_sink
		int   stall;
		res_t got;
		res_t want;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid)
				@(posedge clk);
			got = {res_ch.kind, res_ch.out_byte, res_ch.keep_select, res_ch.last};
			if (beats_due.size() == 0) begin
				err_cnt++;
				$display("%0t unexpected beat: expected none, got %0d/%02h/%0b/%0b",
					$time, got.kind, got.out_byte, got.keep_select, got.last);
			end else begin
				want = beats_due.pop_front();
				if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
						got.keep_select !== want.keep_select || got.last !== want.last) begin
					err_cnt++;
					$display("%0t beat mismatch: expected %0d/%02h/%0b/%0b, got %0d/%02h/%0b/%0b",
						$time, want.kind, want.out_byte, want.keep_select, want.last,
						got.kind, got.out_byte, got.keep_select, got.last);
				end
			end
		end
	end

	// no beat moving on either channel for too long means the block hung
	int unsigned quiet_cycles;
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule
